@@ hw/rtl/c128c_pkg.sv @@
package c128c_pkg;

  localparam int unsigned PATTERN_COUNT = 107;
  localparam int unsigned CHECK_MOD = 103;
  localparam logic [6:0] START_C = 7'd105;
  localparam logic [6:0] STOP_CODE = 7'd106;
  localparam logic [6:0] START_CHECK = 7'(105 % CHECK_MOD);
  localparam logic [6:0] LAST_WEIGHT = 7'(CHECK_MOD - 1);
  localparam logic [6:0] CHECK_MOD_W = 7'(CHECK_MOD);

  // floor(x / 103) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2**14
  localparam int unsigned RECIP_SHIFT = 21;
  localparam logic [14:0] RECIP_MUL = 15'(((1 << RECIP_SHIFT) + CHECK_MOD - 1) / CHECK_MOD);

  // one state word: message flag, running check value, position weight
  localparam int unsigned STATE_W = 15;

  typedef struct packed {
    logic       in_message;
    logic [6:0] check_sum;
    logic [6:0] position_weight;
  } state_t;

  // one character sequence handed from the check pipeline to the emitter
  typedef struct packed {
    logic       has_start;
    logic [6:0] value;
    logic       last;
    logic [6:0] check;
  } job_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_DATA,
    PH_CHECK,
    PH_STOP
  } phase_t;

  // element widths one hex digit each, first element in the top digit;
  // six-element characters carry a zero in the seventh place
  localparam logic [27:0] PATTERN_TABLE [PATTERN_COUNT] = '{
    28'h2122220, 28'h2221220, 28'h2222210, 28'h1212230, 28'h1213220, 28'h1312220,
    28'h1222130, 28'h1223120, 28'h1322120, 28'h2212130, 28'h2213120, 28'h2312120,
    28'h1122320, 28'h1221320, 28'h1222310, 28'h1132220, 28'h1231220, 28'h1232210,
    28'h2232110, 28'h2211320, 28'h2212310, 28'h2132120, 28'h2231120, 28'h3121310,
    28'h3112220, 28'h3211220, 28'h3212210, 28'h3122120, 28'h3221120, 28'h3222110,
    28'h2121230, 28'h2123210, 28'h2321210, 28'h1113230, 28'h1311230, 28'h1313210,
    28'h1123130, 28'h1321130, 28'h1323110, 28'h2113130, 28'h2311130, 28'h2313110,
    28'h1121330, 28'h1123310, 28'h1321310, 28'h1131230, 28'h1133210, 28'h1331210,
    28'h3131210, 28'h2113310, 28'h2311310, 28'h2131130, 28'h2133110, 28'h2131310,
    28'h3111230, 28'h3113210, 28'h3311210, 28'h3121130, 28'h3123110, 28'h3321110,
    28'h3141110, 28'h2214110, 28'h4311110, 28'h1112240, 28'h1114220, 28'h1211240,
    28'h1214210, 28'h1411220, 28'h1412210, 28'h1122140, 28'h1124120, 28'h1221140,
    28'h1224110, 28'h1421120, 28'h1422110, 28'h2412110, 28'h2211140, 28'h4131110,
    28'h2411120, 28'h1341110, 28'h1112420, 28'h1211420, 28'h1212410, 28'h1142120,
    28'h1241120, 28'h1242110, 28'h4112120, 28'h4211120, 28'h4212110, 28'h2121410,
    28'h2141210, 28'h4121210, 28'h1111430, 28'h1113410, 28'h1311410, 28'h1141130,
    28'h1143110, 28'h4111130, 28'h4113110, 28'h1131410, 28'h1141310, 28'h3111410,
    28'h4111310, 28'h2114120, 28'h2112140, 28'h2112320, 28'h2331112
  };

  function automatic logic [27:0] pattern_of(input logic [6:0] code);
    logic [27:0] pat;
    pat = '0;
    if (code <= 7'(PATTERN_COUNT - 1)) begin
      pat = PATTERN_TABLE[code];
    end
    return pat;
  endfunction

endpackage

@@ hw/rtl/code128_set_c_encoder_unit.sv @@
// path: a pair accepted while the emitter is idle passes the three check stages,
//   the emitter's request register, then the output register, before its first
//   element shows on the output
// throughput: one element per cycle while a request is held and out_stall is low;
//   a pair sends start (new message), data, then check and stop (last pair)
// reset: synchronous, active high; clears all valid bits, marks the state word
//   unwritten so the next pair opens a message, and sets module width to 1
module code128_set_c_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  // configuration: module width in pixels
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // digit pair requests
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] tens_digit,
  input  logic [3:0] units_digit,
  input  logic       last_pair,
  // element requests
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] run_width,
  output logic [2:0] module_count,
  output logic       is_bar,
  output logic       end_of_code,
  output logic       end_of_run
);

  logic [7:0]      module_width;
  logic            job_valid;
  logic            job_ready;
  c128c_pkg::job_t job;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_width <= 8'd1;
    end else if (cfg_valid & cfg_ready) begin
      module_width <= cfg_data;
    end
  end

  // check pipeline: reads the state word, folds in the pair value times its
  // weight modulo 103, writes the word back and hands over the characters
  c128c_check u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .tens_digit  (tens_digit),
    .units_digit (units_digit),
    .last_pair   (last_pair),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job)
  );

  // emitter: start, data, check and stop characters, one element per cycle while
  // out_stall is low; it takes the next request from the check pipeline while the
  // last element of the current one leaves
  c128c_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .module_width (module_width),
    .job_in_valid (job_valid),
    .job_ready    (job_ready),
    .job_in       (job),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .run_width    (run_width),
    .module_count (module_count),
    .is_bar       (is_bar),
    .end_of_code  (end_of_code),
    .end_of_run   (end_of_run)
  );

endmodule

@@ hw/rtl/c128c_ram.sv @@
module c128c_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/c128c_check.sv @@
module c128c_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        tens_digit,
  input  logic [3:0]        units_digit,
  input  logic              last_pair,
  output logic              job_valid,
  input  logic              job_ready,
  output c128c_pkg::job_t   job
);

  localparam int unsigned SW = c128c_pkg::STATE_W;

  logic                s1_valid;
  logic                s2_valid;
  logic                s3_valid;
  logic                accept;
  logic                state_valid;
  logic [SW-1:0]       rd_word;
  c128c_pkg::state_t   rd_state;
  c128c_pkg::state_t   wr_state;

  logic [3:0]  s1_tens;
  logic [3:0]  s1_units;
  logic        s1_last;
  logic [3:0]  tens_sat;
  logic [3:0]  units_sat;
  logic [6:0]  value;
  logic        in_msg;
  logic [6:0]  cs_base;
  logic [6:0]  pw_base;
  logic [13:0] product;

  logic        s2_has_start;
  logic [6:0]  s2_value;
  logic        s2_last;
  logic [6:0]  s2_cs;
  logic [6:0]  s2_pw;
  logic [13:0] s2_prod;
  logic [13:0] sum;
  logic [28:0] recip;

  logic        s3_has_start;
  logic [6:0]  s3_value;
  logic        s3_last;
  logic [6:0]  s3_pw;
  logic [13:0] s3_sum;
  logic [6:0]  s3_quot;
  logic [13:0] rem_full;
  logic [6:0]  check;
  logic [6:0]  pw_next;
  logic        retire;

  // one pair in flight between the state read and its write back
  assign in_stall = s1_valid | s2_valid | s3_valid;
  assign accept   = in_valid & ~in_stall;
  assign retire   = s3_valid & job_ready;

  c128c_ram #(
    .WIDTH (SW),
    .DEPTH (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (retire),
    .waddr (1'b0),
    .wdata (wr_state),
    .re    (accept),
    .raddr (1'b0),
    .rdata (rd_word)
  );

  assign rd_state = rd_word;

  // stage 1: state word arrives, digit pair becomes a value and a product
  always_comb begin
    tens_sat  = (s1_tens > 4'd9) ? 4'd9 : s1_tens;
    units_sat = (s1_units > 4'd9) ? 4'd9 : s1_units;
    value     = 7'({tens_sat, 3'b000}) + 7'({tens_sat, 1'b0}) + 7'(units_sat);
    in_msg    = state_valid & rd_state.in_message;
    cs_base   = in_msg ? rd_state.check_sum : c128c_pkg::START_CHECK;
    pw_base   = in_msg ? rd_state.position_weight : 7'd1;
    product   = 14'(value) * 14'(pw_base);
  end

  // stage 2: running sum and quotient estimate by reciprocal
  always_comb begin
    sum   = 14'(s2_cs) + s2_prod;
    recip = 29'(sum) * 29'(c128c_pkg::RECIP_MUL);
  end

  // stage 3: remainder, next weight, write back
  always_comb begin
    rem_full = s3_sum - 14'(s3_quot) * 14'(c128c_pkg::CHECK_MOD_W);
    check    = rem_full[6:0];
    pw_next  = (s3_pw == c128c_pkg::LAST_WEIGHT) ? 7'd0 : s3_pw + 7'd1;
    wr_state.in_message      = ~s3_last;
    wr_state.check_sum       = check;
    wr_state.position_weight = pw_next;
    job.has_start = s3_has_start;
    job.value     = s3_value;
    job.last      = s3_last;
    job.check     = check;
  end

  assign job_valid = s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      state_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        s3_valid <= 1'b1;
      end else if (retire) begin
        s3_valid <= 1'b0;
      end
      if (retire) begin
        state_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tens  <= tens_digit;
      s1_units <= units_digit;
      s1_last  <= last_pair;
    end
    if (s1_valid) begin
      s2_has_start <= ~in_msg;
      s2_value     <= value;
      s2_last      <= s1_last;
      s2_cs        <= cs_base;
      s2_pw        <= pw_base;
      s2_prod      <= product;
    end
    if (s2_valid) begin
      s3_has_start <= s2_has_start;
      s3_value     <= s2_value;
      s3_last      <= s2_last;
      s3_pw        <= s2_pw;
      s3_sum       <= sum;
      s3_quot      <= recip[c128c_pkg::RECIP_SHIFT +: 7];
    end
  end

endmodule

@@ hw/rtl/c128c_emit.sv @@
module c128c_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        module_width,
  input  logic              job_in_valid,
  output logic              job_ready,
  input  c128c_pkg::job_t   job_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [9:0]        run_width,
  output logic [2:0]        module_count,
  output logic              is_bar,
  output logic              end_of_code,
  output logic              end_of_run
);

  c128c_pkg::job_t   job;
  logic              job_valid;
  logic              job_valid_next;
  c128c_pkg::phase_t phase;
  c128c_pkg::phase_t phase_next;
  logic [2:0]        elem;
  logic [2:0]        elem_next;

  logic [6:0]  code_sel;
  logic [27:0] pat;
  logic [27:0] pat_shift;
  logic [2:0]  digit;
  logic [10:0] width_full;
  logic        last_elem;
  logic        emit;
  logic        finish;
  logic        load;

  always_comb begin
    unique case (phase)
      c128c_pkg::PH_START: code_sel = c128c_pkg::START_C;
      c128c_pkg::PH_DATA:  code_sel = job.value;
      c128c_pkg::PH_CHECK: code_sel = job.check;
      c128c_pkg::PH_STOP:  code_sel = c128c_pkg::STOP_CODE;
      default:             code_sel = c128c_pkg::STOP_CODE;
    endcase
    pat        = c128c_pkg::pattern_of(code_sel);
    pat_shift  = pat << {elem, 2'b00};
    digit      = pat_shift[26:24];
    width_full = 11'(digit) * 11'(module_width);
    last_elem  = (phase == c128c_pkg::PH_STOP) ? (elem == 3'd6) : (elem == 3'd5);
    emit       = job_valid & (~out_valid | ~out_stall);
    finish     = emit & last_elem &
                 ((phase == c128c_pkg::PH_STOP) | ((phase == c128c_pkg::PH_DATA) & ~job.last));
    job_ready  = ~job_valid | finish;
    load       = job_ready & job_in_valid;

    phase_next     = phase;
    elem_next      = elem;
    job_valid_next = job_valid;
    if (emit) begin
      if (last_elem) begin
        elem_next = 3'd0;
        unique case (phase)
          c128c_pkg::PH_START: phase_next = c128c_pkg::PH_DATA;
          c128c_pkg::PH_DATA:  phase_next = job.last ? c128c_pkg::PH_CHECK : phase;
          c128c_pkg::PH_CHECK: phase_next = c128c_pkg::PH_STOP;
          c128c_pkg::PH_STOP:  phase_next = phase;
          default:             phase_next = phase;
        endcase
      end else begin
        elem_next = elem + 3'd1;
      end
    end
    if (finish) begin
      job_valid_next = 1'b0;
    end
    if (load) begin
      job_valid_next = 1'b1;
      phase_next     = job_in.has_start ? c128c_pkg::PH_START : c128c_pkg::PH_DATA;
      elem_next      = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      phase     <= c128c_pkg::PH_START;
      elem      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      job_valid <= job_valid_next;
      phase     <= phase_next;
      elem      <= elem_next;
      if (~out_valid | ~out_stall) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
    if (emit) begin
      run_width    <= width_full[9:0];
      module_count <= digit;
      is_bar       <= ~elem[0];
      end_of_code  <= (phase == c128c_pkg::PH_STOP) & last_elem;
      end_of_run   <= finish;
    end
  end

endmodule
